[hdl/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg
// Shared widths, constants, word types and state types for the stereo
// Pade soft clipper.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int IN_WIDTH    = 24;
    localparam int FRAC_BITS   = 20;
    localparam int PEAK_W      = IN_WIDTH + 2;
    localparam int OUT_W       = 16;

    // |x| below 4.0 needs FRAC_BITS + 2 bits
    localparam int T_W         = FRAC_BITS + 2;
    localparam int T2_W        = 2 * T_W;
    localparam int A_W         = 2 * FRAC_BITS + 6;
    localparam int B_W         = 2 * FRAC_BITS + 8;
    // 32767 = 2^15 - 1
    localparam int SCALE_SH    = 15;
    localparam int M_W         = T_W + SCALE_SH;
    localparam int P_W         = M_W + A_W;
    localparam int DIV_STEPS   = OUT_W;
    localparam int DIV_W       = B_W + DIV_STEPS - 1;

    // radix-4 serial multiplier
    localparam int MA_W        = A_W;
    localparam int MB_W        = 2 * ((M_W + 1) / 2);
    localparam int PROD_DIGITS = MB_W / 2;
    localparam int SQR_DIGITS  = (T_W + 1) / 2;
    localparam int CNT_W       = $clog2(PROD_DIGITS + 1);

    localparam logic [A_W-1:0]    PADE_K   = A_W'(27) << (2 * FRAC_BITS);
    localparam logic [OUT_W-1:0]  Q_LIMIT  = OUT_W'(1) << (OUT_W - 1);
    localparam logic [OUT_W-1:0]  POS_MAX  = Q_LIMIT - OUT_W'(1);
    localparam logic [PEAK_W-1:0] PEAK_MAX = PEAK_W'(1) << (PEAK_W - 1);

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] left_in;
        logic signed [IN_WIDTH-1:0] right_in;
        logic                       clear_peak;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
        logic [PEAK_W-1:0]       peak_level;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } step_ctl_t;

    typedef enum logic [3:0] {
        LN_IDLE,
        LN_LOADS,
        LN_SQR,
        LN_PREP,
        LN_LOADM,
        LN_MUL,
        LN_LOADD,
        LN_DIV,
        LN_DONE
    } lane_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_BUSY
    } top_state_t;

    // magnitude of the sample after the gain of 4
    function automatic logic [PEAK_W-1:0] gain_mag(input logic [IN_WIDTH-1:0] x);
        logic [PEAK_W-1:0] g;
        g = {x, 2'b00};
        gain_mag = x[IN_WIDTH-1] ? (~g + PEAK_W'(1)) : g;
    endfunction

endpackage

[hdl/spc_mul.sv]
// ----------------------------------------------------------------------------
// spc_mul
// Radix-4 serial multiplier: one two-bit digit of the multiplier per step cycle,
// low digit first, product bits shifted into the multiplier register.
// ----------------------------------------------------------------------------
module spc_mul import spc_pkg::*; (
    input  logic                   aclk,
    input  step_ctl_t              ctl,
    input  logic [MA_W-1:0]        mcand,
    input  logic [MB_W-1:0]        mplier,
    output logic [MA_W+MB_W-1:0]   product
);

    logic [MA_W-1:0] a1_reg;
    logic [MA_W+1:0] a3_reg;
    logic [MA_W-1:0] hi_reg;
    logic [MB_W-1:0] lo_reg;
    logic [MA_W+1:0] pp;
    logic [MA_W+1:0] sum;

    always_comb begin
        case (lo_reg[1:0])
            2'd0:    pp = '0;
            2'd1:    pp = {2'b00, a1_reg};
            2'd2:    pp = {1'b0, a1_reg, 1'b0};
            default: pp = a3_reg;
        endcase
        sum = {2'b00, hi_reg} + pp;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a1_reg <= mcand;
            a3_reg <= {2'b00, mcand} + {1'b0, mcand, 1'b0};
            hi_reg <= '0;
            lo_reg <= mplier;
        end else if (ctl.step) begin
            hi_reg <= sum[MA_W+1:2];
            lo_reg <= {sum[1:0], lo_reg[MB_W-1:2]};
        end
    end

    assign product = {hi_reg, lo_reg};

endmodule

[hdl/spc_div.sv]
// ----------------------------------------------------------------------------
// spc_div
// Restoring divider, one quotient bit per step cycle, most significant first.
// ----------------------------------------------------------------------------
module spc_div import spc_pkg::*; (
    input  logic                 aclk,
    input  step_ctl_t            ctl,
    input  logic [DIV_W-1:0]     num,
    input  logic [B_W-1:0]       den,
    output logic [DIV_STEPS-1:0] quo
);

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [DIV_W:0]       diff;
    logic                 fits;

    always_comb begin
        diff = {1'b0, rem_reg} - {1'b0, dsr_reg};
        fits = !diff[DIV_W];
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= num;
            dsr_reg <= DIV_W'(den) << (DIV_STEPS - 1);
            quo_reg <= '0;
        end else if (ctl.step) begin
            if (fits) begin
                rem_reg <= diff[DIV_W-1:0];
            end
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= {quo_reg[DIV_STEPS-2:0], fits};
        end
    end

    assign quo = quo_reg;

endmodule

[hdl/spc_lane.sv]
// ----------------------------------------------------------------------------
// spc_lane
// One channel: gain, Pade tanh x(27+x^2)/(27+9x^2) scaled by 32767,
// truncation and 16-bit saturation, sequenced over a serial multiplier
// and a serial divider.
// ----------------------------------------------------------------------------
module spc_lane import spc_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lane_ctl_t                  ctl,
    input  logic signed [IN_WIDTH-1:0] sample,
    output logic                       done,
    output logic [OUT_W-1:0]           result
);

    lane_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [T_W-1:0] t_reg;
    logic           neg_reg;
    logic           sat_reg;
    logic [A_W-1:0] a_reg;
    logic [B_W-1:0] b_reg;
    logic [M_W-1:0] m_reg;

    logic [PEAK_W-1:0]            mag;
    step_ctl_t                    mul_ctl;
    step_ctl_t                    div_ctl;
    logic [MA_W-1:0]              mcand;
    logic [MB_W-1:0]              mplier;
    logic [MA_W+MB_W-1:0]         product;
    logic [MA_W+2*SQR_DIGITS-1:0] sq_bits;
    logic [T2_W-1:0]              t2;
    logic [DIV_STEPS-1:0]         quo;
    logic [OUT_W-1:0]             qc;

    assign mag = gain_mag(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mul_ctl     = '0;
        div_ctl     = '0;
        case (state_reg)
            LN_IDLE: begin
                if (ctl.start) begin
                    state_next = LN_LOADS;
                end
            end
            LN_LOADS: begin
                mul_ctl.load = 1'b1;
                cnt_next     = '0;
                state_next   = LN_SQR;
            end
            LN_SQR: begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQR_DIGITS - 1)) begin
                    state_next = LN_PREP;
                end
            end
            LN_PREP: begin
                state_next = LN_LOADM;
            end
            LN_LOADM: begin
                mul_ctl.load = 1'b1;
                cnt_next     = '0;
                state_next   = LN_MUL;
            end
            LN_MUL: begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PROD_DIGITS - 1)) begin
                    state_next = LN_LOADD;
                end
            end
            LN_LOADD: begin
                div_ctl.load = 1'b1;
                cnt_next     = '0;
                state_next   = LN_DIV;
            end
            LN_DIV: begin
                div_ctl.step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = LN_DONE;
                end
            end
            LN_DONE: begin
                if (ctl.ack) begin
                    state_next = LN_IDLE;
                end
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == LN_IDLE && ctl.start) begin
            t_reg   <= mag[T_W-1:0];
            sat_reg <= |mag[PEAK_W-1:T_W];
            neg_reg <= sample[IN_WIDTH-1];
        end
        if (state_reg == LN_PREP) begin
            a_reg <= PADE_K + A_W'(t2);
            b_reg <= B_W'(PADE_K) + B_W'({t2, 3'b000}) + B_W'(t2);
            m_reg <= {t_reg, {SCALE_SH{1'b0}}} - M_W'(t_reg);
        end
    end

    assign mcand   = (state_reg == LN_LOADS) ? MA_W'(t_reg) : a_reg;
    assign mplier  = (state_reg == LN_LOADS) ? MB_W'(t_reg) : MB_W'(m_reg);
    assign sq_bits = {product[MA_W+MB_W-1:MB_W], product[MB_W-1 -: 2*SQR_DIGITS]};
    assign t2      = sq_bits[T2_W-1:0];

    spc_mul u_mul (
        .aclk    (aclk),
        .ctl     (mul_ctl),
        .mcand   (mcand),
        .mplier  (mplier),
        .product (product)
    );

    spc_div u_div (
        .aclk (aclk),
        .ctl  (div_ctl),
        .num  (product[P_W-1:FRAC_BITS]),
        .den  (b_reg),
        .quo  (quo)
    );

    always_comb begin
        qc = (sat_reg || quo > Q_LIMIT) ? Q_LIMIT : quo;
        if (neg_reg) begin
            result = ~qc + OUT_W'(1);
        end else begin
            result = (qc == Q_LIMIT) ? POS_MAX : qc;
        end
    end

    assign done = (state_reg == LN_DONE);

endmodule

[hdl/stereo_pade_soft_clipper.sv]
// ----------------------------------------------------------------------------
// stereo_pade_soft_clipper
// Stereo soft clipper with gain of 4, Pade tanh curve and running peak meter.
// ----------------------------------------------------------------------------
// Input words (s_valid/s_ready) carry one stereo frame of signed Q4.20
// samples and a clear_peak flag. Output words (m_valid/m_ready) carry the
// two clipped int16 samples and the running peak after gain (Q6.20).
// The peak is updated when the frame is taken, reported with that frame,
// and zeroed afterward when clear_peak is set.
// Both channels run in lockstep, each on its own radix-4 serial multiplier
// (square, then numerator product) and restoring divider (one quotient bit
// per cycle). m_valid rises after both lanes are done and the output is free;
// s_ready returns in the same cycle, so frames are taken one at a time.
// A finished word sits in the output register while the next frame is
// computed; if the receiver still stalls when that frame is done, the
// block holds it and keeps s_ready low until the output register frees.
// Reset (aresetn low, synchronous) zeroes the peak, drops m_valid and
// leaves the block ready for a frame.
// ----------------------------------------------------------------------------
module stereo_pade_soft_clipper import spc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    top_state_t state_reg, state_next;
    logic [PEAK_W-1:0] peak_reg;
    logic [PEAK_W-1:0] rpt_reg;
    logic              m_valid_reg;
    out_word_t         m_data_reg;

    logic              accept;
    logic              out_free;
    logic              load_out;
    lane_ctl_t         lane_ctl;
    logic              done_l, done_r;
    logic [OUT_W-1:0]  res_l, res_r;
    logic [PEAK_W-1:0] mag_l, mag_r, pk, peak_upd;

    assign s_ready  = (state_reg == TOP_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == TOP_BUSY) && done_l && done_r && out_free;

    always_comb begin
        lane_ctl.start = accept;
        lane_ctl.ack   = load_out;
    end

    always_comb begin
        mag_l    = gain_mag(s_data.left_in);
        mag_r    = gain_mag(s_data.right_in);
        pk       = (mag_l > mag_r) ? mag_l : mag_r;
        peak_upd = (pk > peak_reg) ? pk : peak_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE: begin
                if (accept) begin
                    state_next = TOP_BUSY;
                end
            end
            TOP_BUSY: begin
                if (load_out) begin
                    state_next = TOP_IDLE;
                end
            end
            default: begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= TOP_IDLE;
            peak_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= load_out || (m_valid_reg && !m_ready);
            if (accept) begin
                peak_reg <= s_data.clear_peak ? '0 : peak_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rpt_reg <= peak_upd;
        end
        if (load_out) begin
            m_data_reg.left_out   <= $signed(res_l);
            m_data_reg.right_out  <= $signed(res_r);
            m_data_reg.peak_level <= rpt_reg;
        end
    end

    spc_lane u_lane_l (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_data.left_in),
        .done    (done_l),
        .result  (res_l)
    );

    spc_lane u_lane_r (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (lane_ctl),
        .sample  (s_data.right_in),
        .done    (done_r),
        .result  (res_r)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/spc_checker.sv]
// ----------------------------------------------------------------------------
// spc_checker
// Port-level checks for the stereo soft clipper, bound to the top level.
// ----------------------------------------------------------------------------
module spc_checker import spc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // one frame at a time
    a_one_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("frame taken while busy");

    // new result frees the input side in the same cycle
    a_rise_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result shown without input ready");

    a_peak_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.peak_level <= PEAK_MAX)
        else $error("peak level out of range");

    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind stereo_pade_soft_clipper spc_checker u_checker (.*);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo Pade soft clipper. A driver streams
// frames from a queue; each accepted frame is run through an exact-integer
// model of the gain, peak meter and Pade curve, and the monitor compares
// every output word field by field against the oldest prediction. Sender
// gaps and receiver stalls vary across several traffic phases.
// ----------------------------------------------------------------------------
module tb_top import spc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANG_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 120;
    localparam int RAND_FRAMES = 400;
    localparam int PHASES      = 4;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  frame_q[$];
    out_word_t clipped_q[$];
    longint    peak_acc = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        err_cnt = 0;
    int        quiet_cycles = 0;

    stereo_pade_soft_clipper u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // 32767 * tanh-approx of 4*smp, truncated toward zero, saturated to int16
    function automatic logic [OUT_W-1:0] pade_clip(input logic signed [IN_WIDTH-1:0] smp);
        longint     gained;
        longint     mag;
        logic [127:0] w_s, w_t, w_a, w_b, w_n, w_q;
        int         q;
        int         res;
        gained = longint'(smp) * 4;
        mag    = (gained < 0) ? -gained : gained;
        w_s    = 128'(1) << FRAC_BITS;
        w_t    = 128'(mag);
        if (w_t >= 4 * w_s) begin
            q = 32768;
        end else begin
            w_a = 27 * w_s * w_s + w_t * w_t;
            w_b = 27 * w_s * w_s + 9 * w_t * w_t;
            w_n = (32767 * w_t * w_a) >> FRAC_BITS;
            w_q = w_n / w_b;
            q   = (w_q > 128'(32768)) ? 32768 : int'(w_q);
        end
        if (gained < 0)
            res = -q;
        else
            res = (q > 32767) ? 32767 : q;
        return res[OUT_W-1:0];
    endfunction

    function automatic void clip_frame(input in_word_t w);
        out_word_t exp_w;
        longint    mag_l;
        longint    mag_r;
        longint    loud;
        mag_l = longint'(w.left_in) * 4;
        mag_r = longint'(w.right_in) * 4;
        if (mag_l < 0) mag_l = -mag_l;
        if (mag_r < 0) mag_r = -mag_r;
        loud = (mag_l > mag_r) ? mag_l : mag_r;
        if (loud > peak_acc)
            peak_acc = loud;
        exp_w.left_out   = pade_clip(w.left_in);
        exp_w.right_out  = pade_clip(w.right_in);
        exp_w.peak_level = PEAK_W'(peak_acc);
        clipped_q.push_back(exp_w);
        if (w.clear_peak)
            peak_acc = 0;
    endfunction

    task automatic queue_frame(input int l, input int r, input bit clr);
        in_word_t w;
        w.left_in    = l[IN_WIDTH-1:0];
        w.right_in   = r[IN_WIDTH-1:0];
        w.clear_peak = clr;
        frame_q.push_back(w);
    endtask

    function automatic int rand_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return int'($urandom_range(0, 2097152)) - 1048576;
        else if (sel <= 7)
            return int'($urandom());
        else if (sel == 8)
            return ($urandom_range(0, 1) ? 1 : -1) * (1048576 + int'($urandom_range(0, 64)) - 32);
        return int'($urandom_range(0, 510)) - 255;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                clip_frame(s_data);
            if (!s_valid || s_ready) begin
                if (frame_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data  <= frame_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (clipped_q.size() == 0) begin
                    $error("output word with no frame pending");
                    err_cnt++;
                end else begin
                    out_word_t exp_w;
                    exp_w = clipped_q.pop_front();
                    if (m_data.left_out !== exp_w.left_out) begin
                        $error("left_out: expected %0d, got %0d",
                               exp_w.left_out, m_data.left_out);
                        err_cnt++;
                    end
                    if (m_data.right_out !== exp_w.right_out) begin
                        $error("right_out: expected %0d, got %0d",
                               exp_w.right_out, m_data.right_out);
                        err_cnt++;
                    end
                    if (m_data.peak_level !== exp_w.peak_level) begin
                        $error("peak_level: expected %0d, got %0d",
                               exp_w.peak_level, m_data.peak_level);
                        err_cnt++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames, no idling
        queue_frame(0, 0, 1'b0);
        queue_frame(1, -1, 1'b0);
        queue_frame(8388607, -8388608, 1'b0);
        queue_frame(0, 0, 1'b1);
        queue_frame(0, 0, 1'b0);
        queue_frame(1048576, -1048576, 1'b0);
        queue_frame(1048575, -1048575, 1'b1);
        queue_frame(1000, -1000, 1'b0);
        queue_frame(999, 1000, 1'b0);
        queue_frame(-1000, 500, 1'b0);
        queue_frame(2796202, 5592405, 1'b1);
        queue_frame(-2796202, -5592405, 1'b1);
        queue_frame(16384, -16384, 1'b0);
        queue_frame(524288, -524288, 1'b0);
        queue_frame(300000, 700000, 1'b1);
        queue_frame(-900000, 100, 1'b0);
        queue_frame(-8388607, 8388607, 1'b0);
        queue_frame(-1, -1048577, 1'b1);
        queue_frame(1048577, 0, 1'b0);
        queue_frame(-8388608, -8388608, 1'b1);
        while (frame_q.size() != 0) @(posedge aclk);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default: begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                end
            endcase
            for (int i = 0; i < RAND_FRAMES / PHASES; i++)
                queue_frame(rand_sample(), rand_sample(), $urandom_range(0, 7) == 0);
            while (frame_q.size() != 0) @(posedge aclk);
        end

        while (s_valid || clipped_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/spc_pkg.sv
hdl/spc_mul.sv
hdl/spc_div.sv
hdl/spc_lane.sv
hdl/stereo_pade_soft_clipper.sv
hdl/spc_checker.sv
tb/tb_top.sv
